// ===== src/rsn_pkg.sv =====
// Shared widths and payload types for the ray segment nearest hit unit.
`default_nettype none
package rsn_pkg;
  localparam int COORD_W = 24;
  localparam int DIST_W  = 24;
  localparam int SQ_W    = 50;

  typedef struct packed {
    logic                      new_ray;
    logic [DIST_W-1:0]         ray_length;
    logic signed [COORD_W-1:0] ray_start_x;
    logic signed [COORD_W-1:0] ray_start_y;
    logic signed [COORD_W-1:0] ray_end_x;
    logic signed [COORD_W-1:0] ray_end_y;
    logic signed [COORD_W-1:0] wall_a_x;
    logic signed [COORD_W-1:0] wall_a_y;
    logic signed [COORD_W-1:0] wall_b_x;
    logic signed [COORD_W-1:0] wall_b_y;
  } rsn_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]         hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic                      improved;
  } rsn_out_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_CHK  = 7'b0001000,
    ST_SQRT = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_DONE = 7'b1000000
  } rsn_state_t;

  typedef enum logic [3:0] {
    OP_DEN1 = 4'd0, OP_DEN2 = 4'd1, OP_C12A = 4'd2, OP_C12B = 4'd3,
    OP_C34A = 4'd4, OP_C34B = 4'd5, OP_NXA  = 4'd6, OP_NXB  = 4'd7,
    OP_NYA  = 4'd8, OP_NYB  = 4'd9, OP_AX   = 4'd10, OP_AY  = 4'd11
  } rsn_op_t;
endpackage
`default_nettype wire

// ===== src/ray_segment_nearest_hit_unit.sv =====
// Top level: serial ray/wall intersection and nearest hit tracking.
`default_nettype none
// channel | ports                          | transfer when
// input   | in_valid, in_ready, in_data    | in_valid && in_ready
// result  | out_valid, out_ready, out_data | out_valid && out_ready
//
// One wall at a time. Products go through a bit-serial shift-add multiplier,
// ten always and two more when the crossing lies inside both segments and
// its distance does not saturate; the two quotients go through a restoring
// divider one bit a cycle and the root one bit pair a cycle.
// Reset clears the kept hit to zero and the control. The result register
// holds one result while out_ready is low; the next item then waits in done.
module ray_segment_nearest_hit_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsn_pkg::rsn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsn_pkg::rsn_out_t out_data
);
  import rsn_pkg::*;

  localparam int C   = COORD_W;
  localparam int BW  = C + 1;
  // wide enough for the numerators and for the squared distance
  localparam int NW  = (3 * C + 4 > SQ_W) ? 3 * C + 4 : SQ_W;
  localparam int CW  = $clog2(NW);
  localparam logic [DIST_W-1:0] DMASK = {DIST_W{1'b1}};

  rsn_state_t state_r;
  rsn_op_t    op_r;
  logic [CW-1:0] cnt_r;

  logic signed [C-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;

  // multiplier
  logic [NW-1:0] ma_r, acc_r;
  logic [BW-1:0] mb_r;
  logic          mneg_r;
  logic signed [NW-1:0] tmp_r, den_r, c12_r, c34_r, nx_r, ny_r;

  // divider
  logic          dsel_r, qneg_r;
  logic [NW-1:0] dn_r, dd_r, q_r;
  logic [NW:0]   rem_r;
  logic signed [C:0] px_r, py_r;
  logic          pxbig_r, pybig_r;

  // root
  logic [BW-1:0]   ax_r, ay_r;
  logic [SQ_W-1:0] sv_r, sres_r, sbit_r;
  logic [DIST_W-1:0] dist_r;

  logic [DIST_W-1:0] best_d_r;
  logic signed [C-1:0] best_x_r, best_y_r;
  logic     imp_r;
  rsn_out_t out_r;
  logic     out_valid_r;

  logic signed [C:0] d12x, d12y, d34x, d34y;
  assign d12x = {x1_r[C-1], x1_r} - {x2_r[C-1], x2_r};
  assign d12y = {y1_r[C-1], y1_r} - {y2_r[C-1], y2_r};
  assign d34x = {x3_r[C-1], x3_r} - {x4_r[C-1], x4_r};
  assign d34y = {y3_r[C-1], y3_r} - {y4_r[C-1], y4_r};

  // operand selection for the next product
  logic signed [NW-1:0] sel_a;
  logic signed [BW-1:0] sel_b;
  logic                 sel_sq;
  logic [BW-1:0]        sq_b;
  always_comb begin
    sel_a  = '0;
    sel_b  = '0;
    sel_sq = 1'b0;
    sq_b   = ax_r;
    case (op_r)
      OP_DEN1: begin sel_a = NW'(d12x); sel_b = d34y; end
      OP_DEN2: begin sel_a = NW'(d12y); sel_b = d34x; end
      OP_C12A: begin sel_a = NW'(x1_r); sel_b = BW'(y2_r); end
      OP_C12B: begin sel_a = NW'(y1_r); sel_b = BW'(x2_r); end
      OP_C34A: begin sel_a = NW'(x3_r); sel_b = BW'(y4_r); end
      OP_C34B: begin sel_a = NW'(y3_r); sel_b = BW'(x4_r); end
      OP_NXA:  begin sel_a = c12_r; sel_b = d34x; end
      OP_NXB:  begin sel_a = c34_r; sel_b = d12x; end
      OP_NYA:  begin sel_a = c12_r; sel_b = d34y; end
      OP_NYB:  begin sel_a = c34_r; sel_b = d12y; end
      OP_AX:   begin sel_a = signed'(NW'(ax_r)); sel_sq = 1'b1; sq_b = ax_r; end
      OP_AY:   begin sel_a = signed'(NW'(ay_r)); sel_sq = 1'b1; sq_b = ay_r; end
      default: begin sel_a = '0; end
    endcase
  end

  logic [NW-1:0] a_mag;
  logic [BW-1:0] b_mag;
  logic          b_neg;
  assign a_mag = sel_a[NW-1] ? NW'(-sel_a) : NW'(sel_a);
  assign b_neg = sel_sq ? 1'b0 : sel_b[BW-1];
  assign b_mag = sel_sq ? sq_b : (b_neg ? BW'(-sel_b) : BW'(sel_b));

  logic [NW-1:0] acc_nxt;
  logic signed [NW-1:0] prod;
  assign acc_nxt = acc_r + (mb_r[0] ? ma_r : '0);
  assign prod    = mneg_r ? signed'(NW'(-acc_nxt)) : signed'(acc_nxt);

  // restoring divide step
  logic [NW:0]   remsh, rem_nxt;
  logic          ge;
  logic [NW-1:0] q_nxt;
  logic signed [C:0] qs;
  logic          qbig;
  assign remsh   = {rem_r[NW-1:0], dn_r[NW-1]};
  assign ge      = remsh >= {1'b0, dd_r};
  assign rem_nxt = ge ? remsh - {1'b0, dd_r} : remsh;
  assign q_nxt   = {q_r[NW-2:0], ge};
  assign qbig    = |q_nxt[NW-1:C];
  assign qs      = qneg_r ? signed'((C+1)'(-q_nxt[C:0])) : signed'(q_nxt[C:0]);

  // bounding boxes, in C+1 bits
  function automatic logic in_box(input logic signed [C:0] p,
                                  input logic signed [C-1:0] a,
                                  input logic signed [C-1:0] b);
    logic signed [C:0] ea, eb;
    ea = {a[C-1], a};
    eb = {b[C-1], b};
    return ((ea <= p) || (eb <= p)) && ((p <= ea) || (p <= eb))
           && (((ea <= p) && (p <= eb)) || ((eb <= p) && (p <= ea)));
  endfunction

  logic inside_all;
  logic signed [C+1:0] dx, dy;
  logic [C+1:0] adx, ady;
  logic sat;
  assign inside_all = !pxbig_r && !pybig_r &&
                      in_box(px_r, x1_r, x2_r) && in_box(py_r, y1_r, y2_r) &&
                      in_box(px_r, x3_r, x4_r) && in_box(py_r, y3_r, y4_r);
  assign dx  = {px_r[C], px_r} - {{2{x1_r[C-1]}}, x1_r};
  assign dy  = {py_r[C], py_r} - {{2{y1_r[C-1]}}, y1_r};
  assign adx = dx[C+1] ? (C+2)'(-dx) : (C+2)'(dx);
  assign ady = dy[C+1] ? (C+2)'(-dy) : (C+2)'(dy);
  assign sat = (NW'(adx) > NW'(DMASK)) || (NW'(ady) > NW'(DMASK));

  // root step
  logic [SQ_W-1:0] st;
  logic            sge;
  assign st  = sres_r + sbit_r;
  assign sge = sv_r >= st;

  // root result, saturated into the distance field
  logic [SQ_W-1:0] root_fin;
  assign root_fin = sge ? (sres_r >> 1) + sbit_r : sres_r >> 1;

  // result register takes a new transfer when empty or being drained
  logic out_load;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      best_d_r    <= '0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      op_r        <= OP_DEN1;
      cnt_r       <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x1_r <= in_data.ray_start_x;  y1_r <= in_data.ray_start_y;
            x2_r <= in_data.ray_end_x;    y2_r <= in_data.ray_end_y;
            x3_r <= in_data.wall_a_x;     y3_r <= in_data.wall_a_y;
            x4_r <= in_data.wall_b_x;     y4_r <= in_data.wall_b_y;
            if (in_data.new_ray) begin
              best_d_r <= in_data.ray_length;
              best_x_r <= in_data.ray_end_x;
              best_y_r <= in_data.ray_end_y;
            end
            imp_r   <= 1'b0;
            op_r    <= OP_DEN1;
            cnt_r   <= '0;
            acc_r   <= '0;
            mb_r    <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_r == '0) begin
            // load the operands of this product
            ma_r   <= a_mag;
            mb_r   <= b_mag;
            mneg_r <= sel_a[NW-1] ^ b_neg;
            cnt_r  <= CW'(1);
          end else begin
            ma_r  <= {ma_r[NW-2:0], 1'b0};
            mb_r  <= {1'b0, mb_r[BW-1:1]};
            if (cnt_r == CW'(BW)) begin
              acc_r <= '0;
              cnt_r <= '0;
              op_r  <= rsn_op_t'(op_r + 4'd1);
              case (op_r)
                OP_DEN2: den_r <= tmp_r - prod;
                OP_C12B: c12_r <= tmp_r - prod;
                OP_C34B: c34_r <= tmp_r - prod;
                OP_NXB:  nx_r  <= tmp_r - prod;
                OP_NYB: begin
                  ny_r <= tmp_r - prod;
                  if (den_r == '0) begin
                    state_r <= ST_DONE;
                  end else begin
                    dn_r    <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
                    dd_r    <= den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
                    qneg_r  <= nx_r[NW-1] ^ den_r[NW-1];
                    rem_r   <= '0;
                    q_r     <= '0;
                    dsel_r  <= 1'b0;
                    state_r <= ST_DIV;
                  end
                end
                OP_AY: begin
                  sv_r    <= SQ_W'(tmp_r + prod);
                  sres_r  <= '0;
                  sbit_r  <= SQ_W'(1) << (SQ_W - 2);
                  state_r <= ST_SQRT;
                end
                default: tmp_r <= prod;
              endcase
            end else begin
              acc_r <= acc_nxt;
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        ST_DIV: begin
          if (cnt_r == CW'(NW - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            q_r   <= '0;
            if (!dsel_r) begin
              px_r    <= qs;
              pxbig_r <= qbig;
              dn_r    <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
              qneg_r  <= ny_r[NW-1] ^ dd_r[NW-1] ^ den_r[NW-1];
              dsel_r  <= 1'b1;
            end else begin
              py_r    <= qs;
              pybig_r <= qbig;
              state_r <= ST_CHK;
            end
          end else begin
            rem_r <= rem_nxt;
            q_r   <= q_nxt;
            dn_r  <= {dn_r[NW-2:0], 1'b0};
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_CHK: begin
          if (!inside_all) begin
            state_r <= ST_DONE;
          end else if (sat) begin
            dist_r  <= DMASK;
            state_r <= ST_UPD;
          end else begin
            ax_r    <= BW'(adx);
            ay_r    <= BW'(ady);
            op_r    <= OP_AX;
            cnt_r   <= '0;
            acc_r   <= '0;
            mb_r    <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_SQRT: begin
          if (sge) begin
            sv_r   <= sv_r - st;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          if (sbit_r == SQ_W'(1)) begin
            dist_r  <= (root_fin > SQ_W'(DMASK)) ? DMASK : DIST_W'(root_fin);
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (dist_r < best_d_r) begin
            best_d_r <= dist_r;
            best_x_r <= C'(px_r);
            best_y_r <= C'(py_r);
            imp_r    <= 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_r.hit_distance <= best_d_r;
            out_r.hit_x        <= best_x_r;
            out_r.hit_y        <= best_y_r;
            out_r.improved     <= imp_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire
